[sv/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while rst is high.
`define HKPT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that is also evaluated during reset.
`define HKPT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/hkpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkpt_pkg
// Shared types, widths and the hash fold for the hashed key probe table.
// ----------------------------------------------------------------------------
package hkpt_pkg;

   localparam int HASH_W        = 64;
   localparam int VALUE_W       = 32;
   localparam int KEY_W         = 8;
   localparam int SLOT_W        = 8;
   localparam int HASH_SHIFT    = 5;
   localparam int DEPTH_DEFAULT = 256;
   localparam int REQ_DATA_W    = 40;   // key_byte, value_in
   localparam int RSP_DATA_W    = 40;   // value_out, slot_index

   localparam logic [HASH_W-1:0] SEED_RESET = 64'd5381;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [HASH_W-1:0]  hash;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type data;
   } ram_wr_type;

   typedef struct packed {
      logic step;   // fold one key byte
      logic last;   // key complete, reload seed
   } hash_ctl_type;

   // h*33 + byte, modulo 2^64
   function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                   input logic [KEY_W-1:0] b);
      return (h << HASH_SHIFT) + h + HASH_W'(b);
   endfunction

endpackage

[sv/hkpt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkpt_ram
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hkpt_ram
   import hkpt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  ram_wr_type                     wr,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output entry_type                      rd_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/hkpt_hasher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkpt_hasher
// Seed register and running djb2 hash of the key in progress.
// ----------------------------------------------------------------------------
module hkpt_hasher
   import hkpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [HASH_W-1:0] csr_wdata,
   input  hash_ctl_type      ctl,
   input  logic [KEY_W-1:0]  key_byte,
   output logic [HASH_W-1:0] fold_hash    // running hash with key_byte folded in
);

   logic [HASH_W-1:0] seed_ff;
   logic [HASH_W-1:0] run_hash_ff;

   assign fold_hash = fold_byte(run_hash_ff, key_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= SEED_RESET;
         run_hash_ff <= SEED_RESET;
      end else if (csr_we) begin
         // new seed restarts any key in progress
         seed_ff     <= csr_wdata;
         run_hash_ff <= csr_wdata;
      end else if (ctl.step) begin
         run_hash_ff <= ctl.last ? seed_ff : fold_hash;
      end
   end

endmodule

[sv/hashed_key_probe_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_probe_table_top
// Hash table keyed by a djb2 hash of a byte stream, with linear probing.
// ----------------------------------------------------------------------------
// Flow: bytes that are not last are taken one per cycle in the idle state;
//   a last byte runs accept, P probe reads (P = 1..TABLE_DEPTH slots walked,
//   one per cycle through the single read port of the slot memory), reply.
// Result: rsp_tvalid rises from the reply state, held back while a previous
//   result word still waits on rsp_tready.
// Reset: clearing pass over all TABLE_DEPTH slots (req_tready low); seed back to 5381.
// ----------------------------------------------------------------------------
module hashed_key_probe_table_top
   import hkpt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT   // power of two, 2..256
) (
   input  logic                  clock,
   input  logic                  reset,
   // input words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] key_byte, [39:8] value_in
   input  logic                  req_tuser,   // [0] kind (0 insert, 1 lookup)
   input  logic                  req_tlast,   // last_byte
   // result words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] value_out, [39:32] slot_index
   output logic                  rsp_tuser,   // [0] success
   // configuration
   input  logic                  csr_we,
   input  logic [HASH_W-1:0]     csr_wdata    // hash_seed
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [AW-1:0] IDX_LAST = AW'(TABLE_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_REPLY
   } state_type;

   state_type state_ff;

   // key in flight
   logic [HASH_W-1:0]  key_hash_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               kind_ff;
   logic [AW-1:0]      probe_idx_ff;
   logic [AW-1:0]      probe_cnt_ff;
   logic [AW-1:0]      clr_idx_ff;

   // finished result waiting for the output register
   logic               res_ok_ff;
   logic [VALUE_W-1:0] res_value_ff;
   logic [SLOT_W-1:0]  res_slot_ff;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;

   logic               req_fire;
   logic               out_free;
   hash_ctl_type       hash_ctl;
   logic [HASH_W-1:0]  fold_hash;
   ram_wr_type         ram_wr;
   logic [AW-1:0]      ram_wr_addr;
   logic [AW-1:0]      ram_rd_addr;
   entry_type          slot;

   // probe decisions on the slot read last cycle
   logic               slot_free;
   logic               slot_hit;
   logic               walk_done;
   logic               probe_ok;
   logic               probe_end;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign hash_ctl.step = req_fire;
   assign hash_ctl.last = req_tlast;

   hkpt_hasher u_hasher (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .ctl       (hash_ctl),
      .key_byte  (req_tdata[KEY_W-1:0]),
      .fold_hash (fold_hash)
   );

   hkpt_ram #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .wr_addr (ram_wr_addr),
      .rd_addr (ram_rd_addr),
      .rd_data (slot)
   );

   assign slot_free = !slot.valid;
   assign slot_hit  = slot.valid && (slot.hash == key_hash_ff);
   assign walk_done = (probe_cnt_ff == IDX_LAST);

   // insert succeeds on a free slot, lookup on a matching one; an empty slot
   // or a full lap ends the walk either way
   assign probe_ok  = (kind_ff == KIND_INSERT) ? slot_free : slot_hit;
   assign probe_end = probe_ok || slot_free || walk_done;

   // Read address: home slot while the last byte is taken, then the next
   // slot of the walk. Accesses never overlap: the only write of an operation
   // is in its final probe cycle, and the next home-slot read comes after the reply state.
   always_comb begin
      ram_rd_addr = probe_idx_ff + AW'(1);
      if (state_ff == ST_IDLE) begin
         ram_rd_addr = fold_hash[AW-1:0];
      end
   end

   always_comb begin
      ram_wr.en   = 1'b0;
      ram_wr.data = '0;
      ram_wr_addr = probe_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr_addr = clr_idx_ff;
         end
         ST_PROBE: begin
            if (kind_ff == KIND_INSERT && slot_free) begin
               ram_wr.en         = 1'b1;
               ram_wr.data.valid = 1'b1;
               ram_wr.data.hash  = key_hash_ff;
               ram_wr.data.value = value_ff;
            end
         end
         ST_IDLE, ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the reply state reloads the output register itself
         if (rsp_valid_ff && rsp_tready && state_ff != ST_REPLY) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + AW'(1);
               if (clr_idx_ff == IDX_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire && req_tlast) begin
                  key_hash_ff  <= fold_hash;
                  value_ff     <= req_tdata[KEY_W +: VALUE_W];
                  kind_ff      <= req_tuser;
                  probe_idx_ff <= fold_hash[AW-1:0];
                  probe_cnt_ff <= '0;
                  state_ff     <= ST_PROBE;
               end
            end
            ST_PROBE: begin
               if (probe_end) begin
                  res_ok_ff    <= probe_ok;
                  res_value_ff <= (probe_ok && kind_ff == KIND_LOOKUP) ? slot.value : '0;
                  res_slot_ff  <= probe_ok ? SLOT_W'(probe_idx_ff) : '0;
                  state_ff     <= ST_REPLY;
               end
               probe_idx_ff <= probe_idx_ff + AW'(1);
               probe_cnt_ff <= probe_cnt_ff + AW'(1);
            end
            ST_REPLY: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ok_ff    <= res_ok_ff;
                  rsp_value_ff <= res_value_ff;
                  rsp_slot_ff  <= res_slot_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {rsp_slot_ff, rsp_value_ff};

endmodule

[sv/hkpt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkpt_checker
// Port-level checks on the hashed key probe table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hkpt_checker
   import hkpt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // reset starts the clearing pass: no input taken, no result shown
   `HKPT_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> (!req_tready && !rsp_tvalid), "busy after reset")

   // a stalled result word is held
   `HKPT_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "result dropped")

   // a byte that is not last only folds into the hash
   `HKPT_ASSERT(a_byte_ready, clock, reset, (req_tvalid && req_tready && !req_tlast) |=> req_tready, "stall after key byte")

   // a last byte starts the probe walk
   `HKPT_ASSERT(a_last_probe, clock, reset, (req_tvalid && req_tready && req_tlast) |=> !req_tready, "no probe after last byte")

   // a failed operation reports zero value and slot
   `HKPT_ASSERT(a_fail_zero, clock, reset, (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0), "nonzero failed result")

endmodule

bind hashed_key_probe_table_top hkpt_checker u_hkpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
